// File: src/csvp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV byte stream parser - shared types and constants
// Operation codes passed from the byte classifier to the cell emitter, the
// result record, and the character codes the parser reacts to.
// ----------------------------------------------------------------------------
package csvp_pkg;

	localparam int COL_OUT_W = 5;
	localparam int ROW_OUT_W = 24;
	localparam int Q_DEPTH   = 4;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] MARK_B0  = 8'hEF;
	localparam logic [7:0] MARK_B1  = 8'hBB;
	localparam logic [7:0] MARK_B2  = 8'hBF;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_BYTE  = 3'd1,
		OP_COMMA = 3'd2,
		OP_ENDL  = 3'd3,
		OP_STAT  = 3'd4
	} op_kind_t;

	// data carries the cell byte, or the status code for OP_STAT
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
		logic        nonempty;
		logic        item_end;
	} op_t;

	typedef enum logic [1:0] {
		RT_BYTE     = 2'd0,
		RT_CELL_END = 2'd1,
		RT_STATUS   = 2'd2
	} rtype_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY_FILE = 2'd1,
		ST_NO_LINES   = 2'd2
	} status_t;

	typedef struct packed {
		rtype_t                 rtype;
		logic [7:0]             cell_byte;
		logic [COL_OUT_W-1:0]   column_index;
		logic [ROW_OUT_W-1:0]   row_index;
		logic                   is_header;
		logic                   padded;
		logic                   end_of_row;
		status_t                status;
		logic                   last;
	} result_t;

endpackage
`default_nettype wire

// File: src/csv_byte_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV byte stream parser
// Streaming CSV splitter: one file byte per request in, cell bytes, cell ends
// and a final status report out, each tagged with row and column.
// ----------------------------------------------------------------------------
// Feed the file one byte per request (tuser high marks a real byte, tlast
// marks the final request of the file; tlast with tuser low is a bare end).
// A leading EF BB BF mark is dropped, CR LF and LF end a line, commas split
// cells outside quotes, a quote opens quoting anywhere and a doubled quote
// inside quotes yields one quote. The first line is the header and fixes the
// column count (at most MAX_COLUMNS); data lines are padded with empty cells
// or cut to that count, empty data lines vanish, and the row number saturates
// at 2^ROW_BITS-1. At tlast the open line is closed, one status report is sent
// and the parser is back in its reset state for the next file. Each request's
// final result carries tlast on the output. In the classifier a request is
// worked off as steps in this order: held mark bytes released, a replayed lone
// CR, the byte itself, and the line close and report at end of file; a full
// queue stalls it. Operations cross a four-entry queue to the emitter, which
// sends one result per cycle while the output is ready; a short data row is
// closed with one padded empty cell at a time up to the header width, and a
// request whose final result follows another of its own results sends it from
// the holding stage, which takes no new operation until it is released.
// ----------------------------------------------------------------------------
module csv_byte_stream_parser #(
	parameter int MAX_COLUMNS = 32,
	parameter int ROW_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte requests in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // end_of_stream
	// results out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] cell_byte, [12:8] column_index,
	                                    // [36:13] row_index, [37] end_of_row,
	                                    // [39:38] status
	output logic [3:0]  m_axis_tuser,   // [1:0] result_type, [2] is_header, [3] padded
	output logic        m_axis_tlast    // last result of this request
);

	import csvp_pkg::*;

	localparam int OP_W = $bits(op_t);

	op_t            fe_op;
	logic           fe_push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic [OP_W-1:0] q_rdata;
	op_t            be_op;
	logic           res_valid;
	result_t        res;

	// classify bytes into cell operations
	csvp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_has   (s_axis_tuser),
		.in_fin   (s_axis_tlast),
		.op_push  (fe_push),
		.op_data  (fe_op),
		.op_full  (q_full)
	);

	// decouple classifier stalls from padding bursts
	csvp_fifo #(
		.WIDTH (OP_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_op),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign be_op = op_t'(q_rdata);

	// emit cells against row and column bookkeeping
	csvp_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.ROW_BITS    (ROW_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op_data   (be_op),
		.op_pop    (q_pop),
		.res_valid (res_valid),
		.res_ready (m_axis_tready),
		.res_data  (res)
	);

	// pack the result record onto the stream
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {res.status, res.end_of_row, res.row_index,
	                        res.column_index, res.cell_byte};
	assign m_axis_tuser  = {res.padded, res.is_header, res.rtype};
	assign m_axis_tlast  = res.last;

endmodule
`default_nettype wire

// File: src/csvp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser operation queue
// Small first-in first-out buffer between the byte classifier and the cell
// emitter; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module csvp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: src/csvp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser byte classifier
// Strips the byte-order mark, folds CR LF, tracks quoting and turns each
// request into a short list of cell operations for the emitter.
// ----------------------------------------------------------------------------
module csvp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_has,
	input  logic            in_fin,
	output logic            op_push,
	output csvp_pkg::op_t   op_data,
	input  logic            op_full
);

	import csvp_pkg::*;

	localparam int PH_N    = 6;
	localparam int PH_EF   = 0;
	localparam int PH_BB   = 1;
	localparam int PH_CR   = 2;
	localparam int PH_BYTE = 3;
	localparam int PH_ENDL = 4;
	localparam int PH_STAT = 5;

	typedef enum logic [2:0] {
		QS_OUT   = 3'b001,
		QS_IN    = 3'b010,
		QS_CLOSE = 3'b100
	} qstate_t;

	typedef struct packed {
		qstate_t  qs;
		op_kind_t kind;
	} char_res_t;

	function automatic char_res_t char_step(input logic [7:0] c, input qstate_t qs);
		char_res_t r;
		r.qs   = qs;
		r.kind = OP_NONE;
		unique case (qs)
			QS_IN: begin
				if (c == CH_QUOTE) r.qs = QS_CLOSE;
				else r.kind = OP_BYTE;
			end
			QS_CLOSE: begin
				if (c == CH_QUOTE) begin
					r.qs   = QS_IN;
					r.kind = OP_BYTE;
				end else begin
					r.qs = QS_OUT;
					if (c == CH_COMMA) r.kind = OP_COMMA;
					else if (c != CH_CR) r.kind = OP_BYTE;
				end
			end
			QS_OUT: begin
				if (c == CH_QUOTE) r.qs = QS_IN;
				else if (c == CH_COMMA) r.kind = OP_COMMA;
				else if (c != CH_CR) r.kind = OP_BYTE;
			end
			default: begin
				r.qs = QS_OUT;
			end
		endcase
		return r;
	endfunction

	// line and quoting state
	qstate_t    qs_q, p_qs, b_qs;
	logic       pend_q, p_pend, b_pend;
	logic       lempty_q, p_lempty, b_lempty;
	logic       hdone_q, p_hdone, b_hdone;
	logic       seen_q, p_seen, b_seen;
	logic       mark_done_q, p_mark, b_mark;
	logic [1:0] held_q, p_held, b_held;

	// request being worked off
	logic            item_v_q;
	logic [PH_N-1:0] mask_q;
	logic [7:0]      byte_q;
	logic            pushed_q;

	logic [PH_N-1:0] cur;
	logic [PH_N-1:0] mask_rest;
	logic            last_ph;
	logic            push;
	logic            adv;
	logic [7:0]      cc_char;
	char_res_t       cc_res;
	logic            use_cc;
	logic            do_endl;
	op_t             op_n;
	status_t         st_n;

	// accept side
	logic            acc;
	logic [7:0]      mark_exp;
	logic            ph0;
	logic            match;
	logic            mism;
	logic            content;
	logic            mark_a;
	logic [1:0]      held_a;
	logic [1:0]      rel;
	logic [PH_N-1:0] new_mask;

	assign cur       = mask_q & (~mask_q + PH_N'(1));
	assign mask_rest = mask_q & ~cur;
	assign last_ph   = item_v_q && (mask_rest == '0);

	always_comb begin
		if (cur[PH_EF]) cc_char = MARK_B0;
		else if (cur[PH_BB]) cc_char = MARK_B1;
		else if (cur[PH_CR]) cc_char = CH_CR;
		else cc_char = byte_q;
	end

	assign cc_res = char_step(cc_char, qs_q);

	assign st_n = !seen_q ? ST_EMPTY_FILE : (!hdone_q ? ST_NO_LINES : ST_OK);

	always_comb begin
		p_qs     = qs_q;
		p_pend   = pend_q;
		p_lempty = lempty_q;
		p_hdone  = hdone_q;
		p_seen   = seen_q;
		p_mark   = mark_done_q;
		p_held   = held_q;
		use_cc   = 1'b0;
		do_endl  = 1'b0;
		op_n     = '{kind: OP_NONE, data: 8'h00, nonempty: 1'b0, item_end: 1'b0};

		if (item_v_q) begin
			if (cur[PH_EF] || cur[PH_BB]) begin
				use_cc = 1'b1;
			end else if (cur[PH_CR]) begin
				// lone CR replayed as content
				use_cc = 1'b1;
				p_pend = 1'b0;
			end else if (cur[PH_BYTE]) begin
				if (byte_q == CH_LF) do_endl = 1'b1;
				else if (byte_q == CH_CR) p_pend = 1'b1;
				else use_cc = 1'b1;
			end else if (cur[PH_ENDL]) begin
				do_endl = !lempty_q || pend_q;
			end else if (cur[PH_STAT]) begin
				op_n.kind = OP_STAT;
				op_n.data = {6'b0, st_n};
				p_qs      = QS_OUT;
				p_pend    = 1'b0;
				p_lempty  = 1'b1;
				p_hdone   = 1'b0;
				p_seen    = 1'b0;
				p_mark    = 1'b0;
				p_held    = 2'd0;
			end

			if (use_cc) begin
				p_lempty  = 1'b0;
				p_qs      = cc_res.qs;
				op_n.kind = cc_res.kind;
				op_n.data = cc_char;
			end
			if (do_endl) begin
				op_n.kind     = OP_ENDL;
				op_n.nonempty = !lempty_q;
				p_qs          = QS_OUT;
				p_lempty      = 1'b1;
				p_pend        = 1'b0;
				p_hdone       = 1'b1;
			end
		end
		op_n.item_end = last_ph;
	end

	// a request that produced operations closes with a marker even if its
	// final step has nothing to send
	assign push    = item_v_q && ((op_n.kind != OP_NONE) || (last_ph && pushed_q));
	assign adv     = item_v_q && (!push || !op_full);
	assign op_push = push && !op_full;
	assign op_data = op_n;

	assign b_qs     = adv ? p_qs : qs_q;
	assign b_pend   = adv ? p_pend : pend_q;
	assign b_lempty = adv ? p_lempty : lempty_q;
	assign b_hdone  = adv ? p_hdone : hdone_q;
	assign b_seen   = adv ? p_seen : seen_q;
	assign b_mark   = adv ? p_mark : mark_done_q;
	assign b_held   = adv ? p_held : held_q;

	assign in_ready = !item_v_q || (adv && last_ph);
	assign acc      = in_valid && in_ready;

	// mark check and step list for the incoming request, seen after the
	// finishing step of the previous one
	always_comb begin
		unique case (b_held)
			2'd0:    mark_exp = MARK_B0;
			2'd1:    mark_exp = MARK_B1;
			default: mark_exp = MARK_B2;
		endcase
		ph0     = !b_mark;
		match   = in_has && ph0 && (in_byte == mark_exp);
		mism    = in_has && ph0 && !match;
		content = in_has && !match;

		if (match) begin
			held_a = (b_held == 2'd2) ? 2'd0 : b_held + 2'd1;
			mark_a = (b_held == 2'd2);
		end else if (mism) begin
			held_a = 2'd0;
			mark_a = 1'b1;
		end else begin
			held_a = b_held;
			mark_a = b_mark;
		end

		if (mism) rel = b_held;
		else if (in_fin && !mark_a) rel = held_a;
		else rel = 2'd0;

		new_mask          = '0;
		new_mask[PH_EF]   = (rel != 2'd0);
		new_mask[PH_BB]   = (rel == 2'd2);
		new_mask[PH_CR]   = content && b_pend && (in_byte != CH_LF);
		new_mask[PH_BYTE] = content;
		new_mask[PH_ENDL] = in_fin;
		new_mask[PH_STAT] = in_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_q        <= QS_OUT;
			pend_q      <= 1'b0;
			lempty_q    <= 1'b1;
			hdone_q     <= 1'b0;
			seen_q      <= 1'b0;
			mark_done_q <= 1'b0;
			held_q      <= 2'd0;
			item_v_q    <= 1'b0;
			mask_q      <= '0;
			pushed_q    <= 1'b0;
		end else begin
			qs_q     <= b_qs;
			pend_q   <= b_pend;
			lempty_q <= b_lempty;
			hdone_q  <= b_hdone;
			if (acc) begin
				seen_q      <= b_seen | in_has;
				mark_done_q <= mark_a;
				held_q      <= held_a;
				item_v_q    <= (new_mask != '0);
				mask_q      <= new_mask;
				pushed_q    <= 1'b0;
			end else begin
				seen_q      <= b_seen;
				mark_done_q <= b_mark;
				held_q      <= b_held;
				if (adv) begin
					mask_q   <= mask_rest;
					pushed_q <= pushed_q | push;
					if (last_ph) item_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= in_byte;
		end
	end

endmodule
`default_nettype wire

// File: src/csvp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser cell emitter
// Tracks row and column, fixes the header width, pads short rows and cuts
// long ones, and marks the final result of each request.
// ----------------------------------------------------------------------------
module csvp_back #(
	parameter int MAX_COLUMNS = 32,
	parameter int ROW_BITS    = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  csvp_pkg::op_t       op_data,
	output logic                op_pop,
	output logic                res_valid,
	input  logic                res_ready,
	output csvp_pkg::result_t   res_data
);

	import csvp_pkg::*;

	localparam int               COL_W = $clog2(MAX_COLUMNS + 1);
	localparam logic [COL_W-1:0] MAXC  = COL_W'(MAX_COLUMNS);

	logic [COL_W-1:0]    col_q, n_col;
	logic [COL_W-1:0]    hw_q, n_hw;
	logic [ROW_BITS-1:0] row_q, n_row;
	logic                hdone_q, n_hdone;
	logic                lempty_q, n_lempty;
	logic                pad_q, n_pad;

	// holding stage: the newest result waits until it is known whether
	// another one of the same request follows
	logic                hv_q;
	logic                hfin_q;
	result_t             hres_q;
	logic                ov_q;
	result_t             ores_q;

	logic [COL_W-1:0]    lim;
	logic [COL_W:0]      col_p1;
	logic                col_lt_lim;
	logic                col_lt_max;
	logic                eor_lim;
	logic [ROW_BITS-1:0] row_inc;
	logic [ROW_BITS-1:0] row_eff;

	result_t             r;
	result_t             o_n;
	logic                rv;
	logic                done;
	logic                e;
	logic                can_load;
	logic                drain;
	logic                want_out;
	logic                go;

	assign lim        = hdone_q ? hw_q : MAXC;
	assign col_p1     = {1'b0, col_q} + (COL_W+1)'(1);
	assign col_lt_lim = (col_q < lim);
	assign col_lt_max = (col_q < MAXC);
	assign eor_lim    = (col_p1 == {1'b0, lim});
	assign row_inc    = (row_q == '1) ? row_q : row_q + ROW_BITS'(1);
	assign row_eff    = (lempty_q && hdone_q) ? row_inc : row_q;

	always_comb begin
		n_col    = col_q;
		n_hw     = hw_q;
		n_row    = row_q;
		n_hdone  = hdone_q;
		n_lempty = lempty_q;
		n_pad    = pad_q;
		rv       = 1'b0;
		done     = 1'b1;

		r              = '0;
		r.rtype        = RT_BYTE;
		r.column_index = COL_OUT_W'(col_q);
		r.row_index    = ROW_OUT_W'(row_eff);
		r.is_header    = !hdone_q;
		r.status       = ST_OK;

		unique case (op_data.kind)
			OP_NONE: begin
				done = 1'b1;
			end
			OP_BYTE: begin
				rv          = col_lt_lim;
				r.cell_byte = op_data.data;
				n_lempty    = 1'b0;
				n_row       = row_eff;
			end
			OP_COMMA: begin
				rv           = col_lt_lim;
				r.rtype      = RT_CELL_END;
				r.end_of_row = eor_lim;
				n_lempty     = 1'b0;
				n_row        = row_eff;
				if (col_lt_max) n_col = col_p1[COL_W-1:0];
			end
			OP_ENDL: begin
				r.rtype = RT_CELL_END;
				if (pad_q) begin
					// one empty cell a cycle while the output takes it, up to the header width
					rv           = 1'b1;
					r.padded     = 1'b1;
					r.end_of_row = eor_lim;
					if (!eor_lim) begin
						done  = 1'b0;
						n_col = col_p1[COL_W-1:0];
					end
				end else if (!hdone_q) begin
					rv           = col_lt_max;
					r.end_of_row = 1'b1;
					n_hw         = col_lt_max ? col_p1[COL_W-1:0] : MAXC;
					n_hdone      = 1'b1;
				end else if (op_data.nonempty) begin
					rv           = col_lt_lim;
					r.end_of_row = eor_lim;
					n_row        = row_eff;
					if (col_lt_lim && !eor_lim) begin
						done     = 1'b0;
						n_pad    = 1'b1;
						n_lempty = 1'b0;
						n_col    = col_p1[COL_W-1:0];
					end
				end
				if (done) begin
					n_col    = '0;
					n_lempty = 1'b1;
					n_pad    = 1'b0;
				end
			end
			OP_STAT: begin
				rv             = 1'b1;
				r              = '0;
				r.rtype        = RT_STATUS;
				r.status       = status_t'(op_data.data[1:0]);
				n_col          = '0;
				n_hw           = '0;
				n_row          = '0;
				n_hdone        = 1'b0;
				n_lempty       = 1'b1;
				n_pad          = 1'b0;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign e        = done && op_data.item_end;
	assign can_load = !ov_q || res_ready;
	assign drain    = hv_q && hfin_q;
	assign want_out = hv_q ? (rv || e) : (rv && e);
	assign go       = op_valid && !drain && (!want_out || can_load);
	assign op_pop   = go && done;

	assign res_valid = ov_q;
	assign res_data  = ores_q;

	// next output word: the held result (final unless another follows), or
	// the current one straight through when nothing is held
	always_comb begin
		if (hv_q) begin
			o_n      = hres_q;
			o_n.last = drain || !rv;
		end else begin
			o_n      = r;
			o_n.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			hw_q     <= '0;
			row_q    <= '0;
			hdone_q  <= 1'b0;
			lempty_q <= 1'b1;
			pad_q    <= 1'b0;
			hv_q     <= 1'b0;
			hfin_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (go) begin
				col_q    <= n_col;
				hw_q     <= n_hw;
				row_q    <= n_row;
				hdone_q  <= n_hdone;
				lempty_q <= n_lempty;
				pad_q    <= n_pad;
			end

			if (drain && can_load) begin
				hv_q <= 1'b0;
			end else if (go) begin
				if (rv && !(e && !hv_q)) begin
					hv_q   <= 1'b1;
					hfin_q <= e;
				end else if (e) begin
					hv_q <= 1'b0;
				end
			end

			if ((drain && can_load) || (go && want_out)) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((drain && can_load) || (go && want_out)) begin
			ores_q <= o_n;
		end
		if (go && rv && !(e && !hv_q)) begin
			hres_q <= r;
		end
	end

endmodule
`default_nettype wire
